/* rtl/srr_pkg.sv */
// Shared types, constants and codes of the selective-repeat receiver.
package srr_pkg;

  localparam int SEQ_SPACE_DEF = 16;
  localparam int MAX_WINDOW = 8;
  localparam int PAYLOAD_BYTES = 20;
  localparam int PAIRS = PAYLOAD_BYTES / 2;
  localparam int PAYLOAD_W = 8 * PAYLOAD_BYTES;

  localparam int WIN_W = 4;
  localparam int LIM_W = 5;
  localparam int ACK_W = 5;
  localparam int CFG_W = 5;

  localparam logic [4:0] WIN_RESET = 5'd3;
  localparam logic [4:0] LIM_RESET = 5'd6;
  localparam logic [4:0] ACK_NONE = 5'h1F;

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK = 1'b1;

  typedef struct packed {
    logic done;
    logic ok;
  } csum_stat_t;

endpackage

/* rtl/srr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/srr_csum.sv */
// Iterative packet checksum: one shared adder takes two payload bytes per cycle.
module srr_csum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [15:0]                  seq_num_i,
  input  logic signed [31:0]           ack_field_i,
  input  logic signed [31:0]           check_value_i,
  input  logic [srr_pkg::PAYLOAD_W-1:0] payload_i,
  output srr_pkg::csum_stat_t          stat_o
);

  localparam int CNT_W = $clog2(srr_pkg::PAIRS + 1);

  logic                          busy_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [31:0]                   acc_q, acc_d;
  logic [31:0]                   chk_q;
  logic [srr_pkg::PAYLOAD_W-1:0] sh_q;
  logic                          done_q, ok_q;

  assign acc_d = acc_q + {{24{sh_q[7]}}, sh_q[7:0]} + {{24{sh_q[15]}}, sh_q[15:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      ok_q   <= 1'b0;
      acc_q  <= '0;
      chk_q  <= '0;
      sh_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        acc_q  <= {16'd0, seq_num_i} + ack_field_i;
        chk_q  <= check_value_i;
        sh_q   <= payload_i;
      end else if (busy_q) begin
        acc_q <= acc_d;
        sh_q  <= sh_q >> 16;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(srr_pkg::PAIRS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          ok_q   <= (acc_d == chk_q);
        end
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ok   = ok_q;

endmodule

/* rtl/selective_repeat_receiver.sv */
// Selective-repeat receiver top level: packet check, window store and in-order delivery.
// One packet is taken at a time and in_stall_o stays high while it is worked on. The checksum
// runs through one shared adder at two payload bytes per cycle, and the window decision is made
// when it reports done. A packet that is stored then walks the held entries from the window
// base; each stored payload is read in ST_WALK and loaded into the output register in ST_LOAD,
// since the payload store has a registered read port, and every packet ends with one ack item.
// A finished item waits in the output register while the next packet is already accepted.
module selective_repeat_receiver #(
  parameter int SEQ_SPACE = srr_pkg::SEQ_SPACE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [srr_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 seq_num_i,
  input  logic signed [31:0]          ack_field_i,
  input  logic signed [31:0]          check_value_i,
  input  logic [63:0]                 payload_low_i,
  input  logic [63:0]                 payload_mid_i,
  input  logic [31:0]                 payload_high_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [63:0]                 data_low_o,
  output logic [63:0]                 data_mid_o,
  output logic [31:0]                 data_high_o,
  output logic signed [4:0]           ack_value_o,
  output logic signed [4:0]           ack_check_o,
  output logic                        last_o
);

  localparam int IW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam int LW = srr_pkg::LIM_W;
  localparam int WW = srr_pkg::WIN_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_WALK,
    ST_LOAD,
    ST_ACK
  } state_e;

  function automatic logic [LW-1:0] wrap_inc(input logic [LW-1:0] v, input logic [LW-1:0] lim);
    logic [LW:0] n;
    n = (v == srr_pkg::ACK_NONE) ? '0 : {1'b0, v} + 1'b1;
    return (n >= {1'b0, lim}) ? '0 : n[LW-1:0];
  endfunction

  state_e state_q;

  logic [WW-1:0] win_cfg_q;
  logic [LW-1:0] lim_cfg_q;
  logic [WW-1:0] win_eff;
  logic [LW-1:0] lim_eff;

  logic [LW-1:0]  ack_q;
  logic [SEQ_SPACE-1:0] held_q;
  logic [WW-1:0]  w_q;
  logic [LW-1:0]  lim_q;
  logic [LW-1:0]  base_q;
  logic [LW-1:0]  pos_q;
  logic [LW-1:0]  seq_q;
  logic           seq_ok_q;
  logic [WW-1:0]  cnt_q;
  logic [srr_pkg::PAYLOAD_W-1:0] pay_q;

  logic           out_valid_q;
  logic           kind_q, last_q;
  logic [63:0]    dlow_q, dmid_q;
  logic [31:0]    dhigh_q;
  logic [LW-1:0]  ackv_q;

  logic           in_acc, slot_free;
  logic [LW:0]    span;
  logic [LW-1:0]  last_slot;
  logic           in_win;
  logic [IW-1:0]  pos_idx, seq_idx;
  logic           walk_go;
  logic           ram_we, ram_re;
  logic [srr_pkg::PAYLOAD_W-1:0] ram_rdata;
  srr_pkg::csum_stat_t cs_stat;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (win_cfg_q == '0) begin
      win_eff = WW'(1);
    end else if ({2'b00, win_cfg_q} > (WW + 2)'(srr_pkg::MAX_WINDOW)) begin
      win_eff = WW'(srr_pkg::MAX_WINDOW);
    end else begin
      win_eff = win_cfg_q;
    end
    if (lim_cfg_q < LW'(2)) begin
      lim_eff = LW'(2);
    end else if ({2'b00, lim_cfg_q} > (LW + 2)'(SEQ_SPACE)) begin
      lim_eff = LW'(SEQ_SPACE);
    end else begin
      lim_eff = lim_cfg_q;
    end
  end

  always_comb begin
    span      = {1'b0, base_q} + (LW + 1)'(w_q) - 1'b1;
    last_slot = (span >= {1'b0, lim_q}) ? LW'(span - {1'b0, lim_q}) : span[LW-1:0];
    if (!seq_ok_q) begin
      in_win = 1'b0;
    end else if ((LW + 1)'(w_q) >= {1'b0, lim_q}) begin
      in_win = 1'b1;
    end else if (base_q <= last_slot) begin
      in_win = (seq_q >= base_q) && (seq_q <= last_slot);
    end else begin
      in_win = (seq_q >= base_q) || (seq_q <= last_slot);
    end
  end

  assign pos_idx = IW'(pos_q);
  assign seq_idx = IW'(seq_q);
  assign walk_go = (cnt_q < w_q) && held_q[pos_idx];
  assign ram_we  = (state_q == ST_SUM) && cs_stat.done && cs_stat.ok && in_win;
  assign ram_re  = (state_q == ST_WALK) && walk_go && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= srr_pkg::WIN_RESET[WW-1:0];
      lim_cfg_q <= srr_pkg::LIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srr_pkg::CFG_WINDOW: win_cfg_q <= cfg_data_i[WW-1:0];
        srr_pkg::CFG_LIMIT:  lim_cfg_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pay_q <= {payload_high_i, payload_mid_i, payload_low_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ack_q       <= srr_pkg::ACK_NONE;
      held_q      <= '0;
      w_q         <= '0;
      lim_q       <= '0;
      base_q      <= '0;
      pos_q       <= '0;
      seq_q       <= '0;
      seq_ok_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= srr_pkg::KIND_DATA;
      last_q      <= 1'b0;
      dlow_q      <= '0;
      dmid_q      <= '0;
      dhigh_q     <= '0;
      ackv_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_ACK)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            w_q      <= win_eff;
            lim_q    <= lim_eff;
            base_q   <= wrap_inc(ack_q, lim_eff);
            pos_q    <= wrap_inc(ack_q, lim_eff);
            seq_q    <= seq_num_i[LW-1:0];
            seq_ok_q <= seq_num_i < 16'(lim_eff);
            state_q  <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (cs_stat.done) begin
            cnt_q <= '0;
            if (cs_stat.ok && in_win) begin
              held_q[seq_idx] <= 1'b1;
              state_q <= ST_WALK;
            end else begin
              state_q <= ST_ACK;
            end
          end
        end
        ST_WALK: begin
          if (!walk_go) begin
            state_q <= ST_ACK;
          end else if (slot_free) begin
            held_q[pos_idx] <= 1'b0;
            pos_q   <= wrap_inc(pos_q, lim_q);
            ack_q   <= wrap_inc(ack_q, lim_q);
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          out_valid_q <= 1'b1;
          kind_q      <= srr_pkg::KIND_DATA;
          last_q      <= 1'b0;
          ackv_q      <= '0;
          dlow_q      <= ram_rdata[63:0];
          dmid_q      <= ram_rdata[127:64];
          dhigh_q     <= ram_rdata[159:128];
          state_q     <= ST_WALK;
        end
        ST_ACK: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= srr_pkg::KIND_ACK;
            last_q      <= 1'b1;
            ackv_q      <= ack_q;
            dlow_q      <= '0;
            dmid_q      <= '0;
            dhigh_q     <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  srr_csum u_csum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_acc),
    .seq_num_i     (seq_num_i),
    .ack_field_i   (ack_field_i),
    .check_value_i (check_value_i),
    .payload_i     ({payload_high_i, payload_mid_i, payload_low_i}),
    .stat_o        (cs_stat)
  );

  srr_ram #(
    .WIDTH (srr_pkg::PAYLOAD_W),
    .DEPTH (SEQ_SPACE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (seq_idx),
    .wdata_i (pay_q),
    .re_i    (ram_re),
    .raddr_i (pos_idx),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_low_o  = dlow_q;
  assign data_mid_o  = dmid_q;
  assign data_high_o = dhigh_q;
  assign ack_value_o = ackv_q;
  assign ack_check_o = ackv_q;
  assign last_o      = last_q;

endmodule

/* rtl/srr_chk.sv */
// Port-level checker for the selective-repeat receiver, bound to the top level.
module srr_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              kind_o,
  input logic [63:0]       data_low_o,
  input logic [63:0]       data_mid_o,
  input logic [31:0]       data_high_o,
  input logic signed [4:0] ack_value_o,
  input logic signed [4:0] ack_check_o,
  input logic              last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(data_low_o)
      && $stable(data_mid_o) && $stable(data_high_o) && $stable(ack_value_o))
    else $error("Stalled output item changed.");

  a_ack_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ack_check_o == ack_value_o) && (last_o == kind_o))
    else $error("Ack fields of an output item are inconsistent.");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == srr_pkg::KIND_DATA) |-> (ack_value_o == 5'sd0))
    else $error("Delivered payload item carries an ack number.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Receiver accepted a packet without going busy.");

endmodule

bind selective_repeat_receiver srr_chk u_srr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .data_low_o  (data_low_o),
  .data_mid_o  (data_mid_o),
  .data_high_o (data_high_o),
  .ack_value_o (ack_value_o),
  .ack_check_o (ack_check_o),
  .last_o      (last_o)
);
